// ----- hw/rtl/bad_pkg.sv -----
package bad_pkg;

    // Coordinates are taken in their low COORD_BITS bits (8 .. 16 with 16-bit ports).
    localparam int COORD_BITS        = 16;
    localparam int CORDIC_ITERATIONS = 16;
    localparam int ANGLE_TABLE_LEN   = 24;
    localparam int NUM_ITERS         = (CORDIC_ITERATIONS < ANGLE_TABLE_LEN) ?
                                       CORDIC_ITERATIONS : ANGLE_TABLE_LEN;
    localparam int PREC_SHIFT        = 24;

    // field widths
    localparam int BEARING_W = 15;
    localparam int DIST_W    = 20;

    // CORDIC datapath: x, y signed; z in 2^-16 degree
    localparam int CW      = COORD_BITS + PREC_SHIFT + 3;
    localparam int ZW      = 25;
    localparam int ATAN_W  = 22;
    localparam int THETA_W = 23;
    localparam int ANGLE_W = 25;

    // root of 100 * (dx^2 + dy^2) fits COORD_BITS + 4 bits
    localparam int SW = COORD_BITS + 4;

    localparam logic [THETA_W-1:0] THETA_MAX  = THETA_W'(90 * 65536);
    localparam logic [ANGLE_W-1:0] ANGLE_180  = ANGLE_W'(180 * 65536);
    localparam logic [ANGLE_W-1:0] ANGLE_360  = ANGLE_W'(360 * 65536);
    localparam logic [ANGLE_W-1:0] ROUND_HALF = ANGLE_W'(512);
    localparam int                 ROUND_SHIFT = 10;

    localparam logic [BEARING_W-1:0] BEARING_0   = BEARING_W'(0);
    localparam logic [BEARING_W-1:0] BEARING_90  = BEARING_W'(5760);
    localparam logic [BEARING_W-1:0] BEARING_180 = BEARING_W'(11520);
    localparam logic [BEARING_W-1:0] BEARING_270 = BEARING_W'(17280);
    localparam logic [BEARING_W-1:0] FULL_TURN   = BEARING_W'(23040);

    // pipeline latencies, counted in register stages from the input transfer
    localparam int LAT_CORDIC = NUM_ITERS + 1;        // iterations plus clamp
    localparam int LAT_ANGLE  = 1 + LAT_CORDIC + 2;   // front, cordic, map, round
    localparam int LAT_DIST   = 4 + SW;               // front, square, sum, x100, root
    localparam int PIPE_DEPTH = (LAT_ANGLE > LAT_DIST) ? LAT_ANGLE : LAT_DIST;
    localparam int PAD_ANGLE  = PIPE_DEPTH - LAT_ANGLE;
    localparam int PAD_DIST   = PIPE_DEPTH - LAT_DIST;

    typedef struct packed {
        logic coinc;
        logic dx_zero;
        logic dy_zero;
        logic dx_neg;
        logic dy_neg;
    } t_flags;

    // round(atan(2^-i) * 180/pi * 65536)
    function automatic logic [ATAN_W-1:0] atan_entry(input int idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            0:       v = ATAN_W'(2949120);
            1:       v = ATAN_W'(1740967);
            2:       v = ATAN_W'(919879);
            3:       v = ATAN_W'(466945);
            4:       v = ATAN_W'(234379);
            5:       v = ATAN_W'(117304);
            6:       v = ATAN_W'(58666);
            7:       v = ATAN_W'(29335);
            8:       v = ATAN_W'(14668);
            9:       v = ATAN_W'(7334);
            10:      v = ATAN_W'(3667);
            11:      v = ATAN_W'(1833);
            12:      v = ATAN_W'(917);
            13:      v = ATAN_W'(458);
            14:      v = ATAN_W'(229);
            15:      v = ATAN_W'(115);
            16:      v = ATAN_W'(57);
            17:      v = ATAN_W'(29);
            18:      v = ATAN_W'(14);
            19:      v = ATAN_W'(7);
            20:      v = ATAN_W'(4);
            21:      v = ATAN_W'(2);
            22:      v = ATAN_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/bearing_and_distance.sv -----
// Bearing and distance from a robot position to a target position. One coordinate
// set is taken per cycle while the output is not stalled, and each result goes
// through PIPE_DEPTH register stages from its input transfer: the 20-stage restoring
// square root (one result bit per stage), fed by square, sum and times-ten-squared
// stages behind the difference stage, sets that depth; the bearing path (16-stage
// CORDIC, clamp, quadrant map, rounding) is padded to match. The bearing is in 1/64
// degree counter-clockwise from +x, and coincident points give bearing 0, distance 0
// and the coincident flag. When the output is stalled the whole pipeline holds, and
// input ready follows output ready whenever a result is waiting.
module bearing_and_distance (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [15:0]                i_target_x,
    input  logic signed [15:0]                i_robot_x,
    input  logic signed [15:0]                i_target_y,
    input  logic signed [15:0]                i_robot_y,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [bad_pkg::BEARING_W-1:0]     o_bearing,
    output logic [bad_pkg::DIST_W-1:0]        o_scaled_distance,
    output logic                              o_coincident
);
    import bad_pkg::*;

    localparam int C = COORD_BITS;

    logic                  w_en;
    logic [PIPE_DEPTH-1:0] r_vld;

    // front stage
    logic signed [C:0] w_tx, w_rx, w_ty, w_ry, w_dx, w_dy;
    logic [C:0]        w_adx, w_ady;
    t_flags            w_flags;
    logic [C-1:0]      r_ax, r_ay;
    t_flags            r_flags;

    // distance path
    logic [2*C-1:0]  r_sqx, r_sqy;
    logic [2*C:0]    r_sum;
    logic [2*SW-1:0] w_sum_ext;
    logic [2*SW-1:0] r_rad;
    logic [SW-1:0]   w_root;

    // angle path
    logic [THETA_W-1:0] w_theta;
    t_flags             r_fd [LAT_CORDIC];
    t_flags             r_fq;
    logic [ANGLE_W-1:0] r_ang;
    logic [ANGLE_W-1:0] w_rnd;
    logic [BEARING_W-1:0] w_bq;
    logic [BEARING_W-1:0] r_bear;
    logic                 r_coinc;

    assign w_en       = !r_vld[PIPE_DEPTH-1] || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_in_valid};
        end
    end

    assign w_tx = $signed({i_target_x[C-1], i_target_x[C-1:0]});
    assign w_rx = $signed({i_robot_x[C-1], i_robot_x[C-1:0]});
    assign w_ty = $signed({i_target_y[C-1], i_target_y[C-1:0]});
    assign w_ry = $signed({i_robot_y[C-1], i_robot_y[C-1:0]});
    assign w_dx = w_tx - w_rx;
    assign w_dy = w_ty - w_ry;
    assign w_adx = w_dx[C] ? (C+1)'(-w_dx) : w_dx;
    assign w_ady = w_dy[C] ? (C+1)'(-w_dy) : w_dy;

    always_comb begin
        w_flags.dx_zero = (w_dx == '0);
        w_flags.dy_zero = (w_dy == '0);
        w_flags.coinc   = w_flags.dx_zero && w_flags.dy_zero;
        w_flags.dx_neg  = w_dx[C];
        w_flags.dy_neg  = w_dy[C];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ax    <= w_adx[C-1:0];
            r_ay    <= w_ady[C-1:0];
            r_flags <= w_flags;
        end
    end

    // ---- distance: isqrt(100 * (ax^2 + ay^2))
    assign w_sum_ext = (2*SW)'(r_sum);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sqx <= r_ax * r_ax;
            r_sqy <= r_ay * r_ay;
            r_sum <= {1'b0, r_sqx} + {1'b0, r_sqy};
            r_rad <= (w_sum_ext << 6) + (w_sum_ext << 5) + (w_sum_ext << 2);
        end
    end

    bad_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_rad),
        .o_root (w_root)
    );

    // ---- bearing
    bad_cordic u_cordic (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_ax    (r_ax),
        .i_ay    (r_ay),
        .o_theta (w_theta)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fd[0] <= r_flags;
            for (int k = 1; k < LAT_CORDIC; k++) begin
                r_fd[k] <= r_fd[k-1];
            end
        end
    end

    // quadrant map
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fq <= r_fd[LAT_CORDIC-1];
            if (!r_fd[LAT_CORDIC-1].dx_neg && !r_fd[LAT_CORDIC-1].dy_neg) begin
                r_ang <= ANGLE_W'(w_theta);
            end else if (r_fd[LAT_CORDIC-1].dx_neg && !r_fd[LAT_CORDIC-1].dy_neg) begin
                r_ang <= ANGLE_180 - ANGLE_W'(w_theta);
            end else if (r_fd[LAT_CORDIC-1].dx_neg) begin
                r_ang <= ANGLE_180 + ANGLE_W'(w_theta);
            end else begin
                r_ang <= ANGLE_360 - ANGLE_W'(w_theta);
            end
        end
    end

    assign w_rnd = r_ang + ROUND_HALF;
    assign w_bq  = w_rnd[ROUND_SHIFT +: BEARING_W];

    // round to 1/64 degree, wrap a full turn, axis and coincident overrides
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_coinc <= r_fq.coinc;
            if (r_fq.coinc) begin
                r_bear <= BEARING_0;
            end else if (r_fq.dy_zero) begin
                r_bear <= r_fq.dx_neg ? BEARING_180 : BEARING_0;
            end else if (r_fq.dx_zero) begin
                r_bear <= r_fq.dy_neg ? BEARING_270 : BEARING_90;
            end else if (w_bq >= FULL_TURN) begin
                r_bear <= w_bq - FULL_TURN;
            end else begin
                r_bear <= w_bq;
            end
        end
    end

    // ---- align both paths to PIPE_DEPTH
    if (PAD_ANGLE == 0) begin : g_ang_direct
        assign o_bearing    = r_bear;
        assign o_coincident = r_coinc;
    end else begin : g_ang_pad
        logic [BEARING_W:0] r_pa [PAD_ANGLE];
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_pa[0] <= {r_coinc, r_bear};
                for (int k = 1; k < PAD_ANGLE; k++) begin
                    r_pa[k] <= r_pa[k-1];
                end
            end
        end
        assign o_bearing    = r_pa[PAD_ANGLE-1][BEARING_W-1:0];
        assign o_coincident = r_pa[PAD_ANGLE-1][BEARING_W];
    end

    if (PAD_DIST == 0) begin : g_dist_direct
        assign o_scaled_distance = DIST_W'(w_root);
    end else begin : g_dist_pad
        logic [SW-1:0] r_pd [PAD_DIST];
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_pd[0] <= w_root;
                for (int k = 1; k < PAD_DIST; k++) begin
                    r_pd[k] <= r_pd[k-1];
                end
            end
        end
        assign o_scaled_distance = DIST_W'(r_pd[PAD_DIST-1]);
    end

    assign o_out_valid = r_vld[PIPE_DEPTH-1];

endmodule

// ----- hw/rtl/bad_cordic.sv -----
module bad_cordic (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [bad_pkg::COORD_BITS-1:0]   i_ax,
    input  logic [bad_pkg::COORD_BITS-1:0]   i_ay,
    output logic [bad_pkg::THETA_W-1:0]      o_theta
);
    import bad_pkg::*;

    logic signed [CW-1:0] r_x [NUM_ITERS];
    logic signed [CW-1:0] r_y [NUM_ITERS];
    logic signed [ZW-1:0] r_z [NUM_ITERS];
    logic [THETA_W-1:0]   r_theta;
    logic signed [ZW-1:0] w_zf;

    for (genvar i = 0; i < NUM_ITERS; i++) begin : g_iter
        logic signed [CW-1:0] x_in;
        logic signed [CW-1:0] y_in;
        logic signed [ZW-1:0] z_in;
        logic signed [ZW-1:0] z_step;

        if (i == 0) begin : g_first
            assign x_in = $signed({3'b000, i_ax, {PREC_SHIFT{1'b0}}});
            assign y_in = $signed({3'b000, i_ay, {PREC_SHIFT{1'b0}}});
            assign z_in = '0;
        end else begin : g_next
            assign x_in = r_x[i-1];
            assign y_in = r_y[i-1];
            assign z_in = r_z[i-1];
        end

        assign z_step = $signed({{(ZW-ATAN_W){1'b0}}, atan_entry(i)});

        // floor shifts are arithmetic shifts
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!y_in[CW-1]) begin
                    r_x[i] <= x_in + (y_in >>> i);
                    r_y[i] <= y_in - (x_in >>> i);
                    r_z[i] <= z_in + z_step;
                end else begin
                    r_x[i] <= x_in - (y_in >>> i);
                    r_y[i] <= y_in + (x_in >>> i);
                    r_z[i] <= z_in - z_step;
                end
            end
        end
    end

    assign w_zf = r_z[NUM_ITERS-1];

    // clamp to 0 .. 90 degrees
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_zf[ZW-1]) begin
                r_theta <= '0;
            end else if (w_zf[ZW-2:0] > (ZW-1)'(THETA_MAX)) begin
                r_theta <= THETA_MAX;
            end else begin
                r_theta <= w_zf[THETA_W-1:0];
            end
        end
    end

    assign o_theta = r_theta;

endmodule

// ----- hw/rtl/bad_isqrt.sv -----
module bad_isqrt (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [2*bad_pkg::SW-1:0]   i_rad,
    output logic [bad_pkg::SW-1:0]     o_root
);
    import bad_pkg::*;

    localparam int RMW = SW + 3;

    logic [RMW-1:0]  r_rem  [SW];
    logic [SW-1:0]   r_root [SW];
    logic [2*SW-1:0] r_rad  [SW];

    // one result bit per stage, radicand consumed two bits at a time from the top
    for (genvar k = 0; k < SW; k++) begin : g_digit
        logic [RMW-1:0]  rem_in;
        logic [SW-1:0]   root_in;
        logic [2*SW-1:0] rad_in;
        logic [RMW-1:0]  rem_t;
        logic [RMW-1:0]  trial;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
        end

        assign rem_t = {rem_in[SW:0], rad_in[2*SW-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k] <= {rad_in[2*SW-3:0], 2'b00};
                if (rem_t >= trial) begin
                    r_rem[k]  <= rem_t - trial;
                    r_root[k] <= {root_in[SW-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= rem_t;
                    r_root[k] <= {root_in[SW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_root[SW-1];

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    import bad_pkg::*;

    typedef struct packed {
        logic signed [15:0] target_x;
        logic signed [15:0] robot_x;
        logic signed [15:0] target_y;
        logic signed [15:0] robot_y;
    } coord_set_t;

    typedef struct packed {
        logic [BEARING_W-1:0] bearing;
        logic [DIST_W-1:0]    scaled_distance;
        logic                 coincident;
    } fix_t;

    // atan(2^-k) in 2^-16 degree
    localparam longint ARCTAN_STEP [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };
    localparam longint QUARTER_TURN = 90 * 65536;
    localparam longint HALF_TURN    = 180 * 65536;
    localparam longint WHOLE_TURN   = 360 * 65536;
    localparam int     TURN_UNITS   = 23040;
    localparam int     DRAIN_CYCLES = PIPE_DEPTH + 16;
    localparam int     HOLD_CYCLES  = 300;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             i_out_ready = 1'b0;
    logic             o_in_ready;
    logic             o_out_valid;
    logic [BEARING_W-1:0] o_bearing;
    logic [DIST_W-1:0]    o_scaled_distance;
    logic             o_coincident;
    coord_set_t       offered = '0;

    coord_set_t coord_sets[$];
    fix_t       fixes_due[$];
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         hold_requests = 0;
    int         holds_served = 0;
    int         hold_left = 0;
    int         errors = 0;

    bearing_and_distance DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_target_x        (offered.target_x),
        .i_robot_x         (offered.robot_x),
        .i_target_y        (offered.target_y),
        .i_robot_y         (offered.robot_y),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_bearing         (o_bearing),
        .o_scaled_distance (o_scaled_distance),
        .o_coincident      (o_coincident)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned probe;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > n)
            probe = probe >> 2;
        while (probe != 0) begin
            if (n >= root + probe) begin
                n = n - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic fix_t predict_fix(coord_set_t c);
        longint dx, dy, ax, ay, x, y, z, xs, ys, angle, units;
        longint unsigned sq;
        fix_t f;
        dx = longint'(c.target_x) - longint'(c.robot_x);
        dy = longint'(c.target_y) - longint'(c.robot_y);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        sq = ax * ax + ay * ay;
        f.scaled_distance = DIST_W'(int_sqrt(sq * 100));
        f.coincident = 1'b0;
        if (dx == 0 && dy == 0) begin
            f = '0;
            f.coincident = 1'b1;
            return f;
        end
        if (dy == 0) begin
            units = (dx > 0) ? 0 : TURN_UNITS / 2;
        end else if (dx == 0) begin
            units = (dy > 0) ? TURN_UNITS / 4 : 3 * TURN_UNITS / 4;
        end else begin
            // vectoring CORDIC on |dx|, |dy|; >>> on signed is a floor shift
            x = ax <<< PREC_SHIFT;
            y = ay <<< PREC_SHIFT;
            z = 0;
            for (int k = 0; k < CORDIC_ITERATIONS && k < 24; k++) begin
                xs = x >>> k;
                ys = y >>> k;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ARCTAN_STEP[k];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ARCTAN_STEP[k];
                end
            end
            if (z < 0)
                z = 0;
            if (z > QUARTER_TURN)
                z = QUARTER_TURN;
            if (dx > 0 && dy > 0)
                angle = z;
            else if (dx < 0 && dy > 0)
                angle = HALF_TURN - z;
            else if (dx < 0)
                angle = HALF_TURN + z;
            else
                angle = WHOLE_TURN - z;
            units = (angle + 512) >>> 10;
            if (units >= TURN_UNITS)
                units = units - TURN_UNITS;
        end
        f.bearing = BEARING_W'(units);
        return f;
    endfunction

    function automatic logic signed [15:0] pick_extreme();
        case ($urandom_range(4))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic coord_set_t random_coords();
        coord_set_t c;
        int r, d, t;
        c.target_x = 16'($urandom);
        c.robot_x  = 16'($urandom);
        c.target_y = 16'($urandom);
        c.robot_y  = 16'($urandom);
        case ($urandom_range(9))
            4, 5: begin
                // target close to robot: short vectors, all directions
                r = int'(c.robot_x);
                d = int'($urandom_range(100)) - 50;
                t = (r + d > 32767 || r + d < -32768) ? r - d : r + d;
                c.target_x = 16'(t);
                r = int'(c.robot_y);
                d = int'($urandom_range(100)) - 50;
                t = (r + d > 32767 || r + d < -32768) ? r - d : r + d;
                c.target_y = 16'(t);
            end
            6: begin
                if ($urandom_range(1))
                    c.target_x = c.robot_x;
                else
                    c.target_y = c.robot_y;
            end
            7: begin
                if ($urandom_range(1)) begin
                    c.target_x = c.robot_x;
                    c.target_y = c.robot_y;
                end
            end
            8: begin
                c.target_x = pick_extreme();
                c.robot_x  = pick_extreme();
                c.target_y = pick_extreme();
                c.robot_y  = pick_extreme();
            end
            9: begin
                c.target_x = 16'(int'($urandom_range(2000)) - 1000);
                c.robot_x  = 16'(int'($urandom_range(2000)) - 1000);
                c.target_y = 16'(int'($urandom_range(2000)) - 1000);
                c.robot_y  = 16'(int'($urandom_range(2000)) - 1000);
            end
            default: ;
        endcase
        return c;
    endfunction

    task automatic push_coords(int tx, int rx, int ty, int ry);
        coord_set_t c;
        c.target_x = 16'(tx);
        c.robot_x  = 16'(rx);
        c.target_y = 16'(ty);
        c.robot_y  = 16'(ry);
        coord_sets.push_back(c);
    endtask

    task automatic push_random(int count);
        for (int n = 0; n < count; n++)
            coord_sets.push_back(random_coords());
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (coord_sets.size() != 0 || i_in_valid || fixes_due.size() != 0);
    endtask

    // driver: predicts each transfer, then offers the next queued set
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                fixes_due.push_back(predict_fix(offered));
            if (!i_in_valid || o_in_ready) begin
                if (coord_sets.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered <= coord_sets.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each transfer, drives ready with random stalls and long holds
    always @(posedge i_clk) begin : monitor
        fix_t want;
        if (i_out_ready && o_out_valid) begin
            if (fixes_due.size() == 0) begin
                $display("%0t: unexpected result bearing %0d distance %0d coincident %0b",
                         $time, o_bearing, o_scaled_distance, o_coincident);
                errors++;
            end else begin
                want = fixes_due.pop_front();
                if (o_bearing !== want.bearing) begin
                    $display("%0t: bearing expected %0d actual %0d",
                             $time, want.bearing, o_bearing);
                    errors++;
                end
                if (o_scaled_distance !== want.scaled_distance) begin
                    $display("%0t: scaled_distance expected %0d actual %0d",
                             $time, want.scaled_distance, o_scaled_distance);
                    errors++;
                end
                if (o_coincident !== want.coincident) begin
                    $display("%0t: coincident expected %0b actual %0b",
                             $time, want.coincident, o_coincident);
                    errors++;
                end
            end
        end
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        send_idle_pct = 26;
        recv_idle_pct = 48;
        // coincident points
        push_coords(0, 0, 0, 0);
        push_coords(-32768, -32768, 32767, 32767);
        // axis directions at full length
        push_coords(32767, -32768, 0, 0);
        push_coords(-32768, 32767, 5, 5);
        push_coords(100, 100, 32767, -32768);
        push_coords(100, 100, -32768, 32767);
        // diagonals at maximum distance, one per quadrant
        push_coords(32767, -32768, 32767, -32768);
        push_coords(-32768, 32767, 32767, -32768);
        push_coords(-32768, 32767, -32768, 32767);
        push_coords(32767, -32768, -32768, 32767);
        // angles just off each axis; the first one rounds up to a full turn
        push_coords(32767, -32768, -1, 0);
        push_coords(32767, -32768, 1, 0);
        push_coords(1, 0, 32767, -32768);
        push_coords(-1, 0, 32767, -32768);
        push_coords(-32768, 32767, 1, 0);
        push_coords(-32768, 32767, -1, 0);
        push_coords(1, 0, -32768, 32767);
        push_coords(-1, 0, -32768, 32767);
        // short vectors
        push_coords(1, 0, 1, 0);
        push_coords(3, 0, 4, 0);
        push_coords(-3, 0, -4, 0);
        push_coords(1, 0, 2, 0);
        push_coords(7, 3, -12, 9);
        push_random(400);
        wait_drained();

        send_idle_pct = 48;
        recv_idle_pct = 26;
        push_random(400);
        wait_drained();

        // no idling; one long receiver hold-off fills the pipeline
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests = hold_requests + 1;
        push_random(400);
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #2_400_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
